// ----- rtl/core/bezier_curve_point_evaluator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Bezier curve point evaluator core
// Each macro states one clocked implication with reset disabled.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_POINT_EVALUATOR_CORE_ASSERT_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_CORE_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define BCPE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define BCPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bcpe_pkg
// Types and constants shared by the Bezier curve point evaluator core.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  localparam int ORDER_BITS     = 4;
  localparam int STEPS_BITS     = 10;
  localparam int INDEX_BITS     = 4;
  localparam int SAMPLE_BITS    = 10;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 4'd3;
  localparam logic [STEPS_BITS-1:0] STEPS_RESET = 10'd100;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_ORDER  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_STEPS = 1'b1;

  localparam logic OP_WRITE_POINT = 1'b0;
  localparam logic OP_EVALUATE    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEVEL,
    ST_DRAIN,
    ST_DIRECT_RD,
    ST_DIRECT_OUT
  } state_t;

endpackage

// ----- rtl/core/bezier_curve_point_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_core
// Stores control points and evaluates a Bezier curve point by de Casteljau
// with one shared interpolation pipeline working out of a scratch memory.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     start, busy         in_opcode, in_point_index, in_coord_x/y,
//                                in_sample_index
//  result    out_valid strobe    out_curve_x, out_curve_y, out_is_last_sample
//  config    cfg_we              cfg_index, cfg_wdata
//
// A point write leaves busy low.
// An evaluation first works out t by bit-serial division, then runs n levels for
// order n; order zero reads control point zero out directly.
// Each level streams one memory read per cycle and drains the three-stage
// interpolation pipeline before the next level reads its results.
// The result strobe lasts one cycle and cannot be stalled. Reset is synchronous.
module bezier_curve_point_evaluator_core #(
  parameter int MAX_POINTS  = 16,
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_opcode,
  input  logic [bcpe_pkg::INDEX_BITS-1:0]       in_point_index,
  input  logic signed [COORD_BITS-1:0]          in_coord_x,
  input  logic signed [COORD_BITS-1:0]          in_coord_y,
  input  logic [bcpe_pkg::SAMPLE_BITS-1:0]      in_sample_index,
  output logic                                  out_valid,
  output logic signed [COORD_BITS-1:0]          out_curve_x,
  output logic signed [COORD_BITS-1:0]          out_curve_y,
  output logic                                  out_is_last_sample,
  input  logic                                  cfg_we,
  input  logic [bcpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bcpe_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import bcpe_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int WW   = 2 * COORD_BITS;
  localparam int TW   = T_FRAC_BITS + 1;
  localparam int DW   = SAMPLE_BITS + T_FRAC_BITS;
  localparam int CNTW = $clog2(DW + 1);
  localparam int RW   = STEPS_BITS + 1;
  localparam int DFW  = COORD_BITS + 1;
  localparam int PW   = DFW + TW + 1;

  localparam logic [AW-1:0]          N_MAX  = AW'(MAX_POINTS - 1);
  localparam logic [CNTW-1:0]        DIV_N  = CNTW'(DW);
  localparam logic signed [PW-1:0]   HALF   = PW'(longint'(1) << (T_FRAC_BITS - 1));

  state_t state_r, state_nxt;

  logic [ORDER_BITS-1:0] curve_order_r;
  logic [STEPS_BITS-1:0] sample_steps_r;

  logic [WW-1:0] ctrl_mem [MAX_POINTS];
  logic [WW-1:0] work_mem [MAX_POINTS];
  logic [WW-1:0] ctrl_q, work_q;

  logic                   acc, wr_acc, ev_acc, wr_in_range;
  logic [AW-1:0]          wr_addr;
  logic [STEPS_BITS-1:0]  steps_eff, k_cl;
  logic [AW-1:0]          n_eval;

  logic [STEPS_BITS-1:0]  div_d_r, rem_r;
  logic [DW-1:0]          dvd_r;
  logic [CNTW-1:0]        cnt_r;
  logic [RW-1:0]          rem_sh;
  logic                   q_bit;
  logic                   last_r;

  logic [AW-1:0]          n_r, lvl_r, j_r;
  logic                   first_r;

  logic                   rd_vld_r, rd_first_r, rd_final_r;
  logic [AW-1:0]          rd_idx_r;
  logic [WW-1:0]          cur_w, prev_r;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y;

  logic                   s1_vld_r, s1_final_r;
  logic [AW-1:0]          w1_idx_r;
  logic signed [DFW-1:0]  diff_x_r, diff_y_r;
  logic signed [COORD_BITS-1:0] p1_x_r, p1_y_r;

  logic                   s2_vld_r, s2_final_r;
  logic [AW-1:0]          w2_idx_r;
  logic signed [PW-1:0]   prod_x_r, prod_y_r;
  logic signed [COORD_BITS-1:0] p2_x_r, p2_y_r;

  logic signed [TW:0]     t_s;
  logic signed [PW-1:0]   rnd_x, rnd_y;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic                   pipe_empty;

  logic                   out_valid_r, out_last_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;

  // Input decode.
  assign acc         = start && !busy;
  assign wr_acc      = acc && (in_opcode == OP_WRITE_POINT);
  assign ev_acc      = acc && (in_opcode == OP_EVALUATE);
  assign wr_in_range = (32'(in_point_index) < 32'(MAX_POINTS));
  assign wr_addr     = AW'(in_point_index);

  always_comb begin
    steps_eff = (sample_steps_r == '0) ? STEPS_BITS'(1) : sample_steps_r;
    k_cl      = (STEPS_BITS'(in_sample_index) > steps_eff) ? steps_eff
                                                            : STEPS_BITS'(in_sample_index);
    n_eval    = (32'(curve_order_r) > 32'(MAX_POINTS - 1)) ? N_MAX : AW'(curve_order_r);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_order_r  <= ORDER_RESET;
      sample_steps_r <= STEPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURVE_ORDER:  curve_order_r  <= cfg_wdata[ORDER_BITS-1:0];
        REG_SAMPLE_STEPS: sample_steps_r <= cfg_wdata[STEPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Control point memory and scratch memory.
  always_ff @(posedge clk) begin
    if (wr_acc && wr_in_range) begin
      ctrl_mem[wr_addr] <= {in_coord_x, in_coord_y};
    end
    ctrl_q <= ctrl_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      work_mem[w2_idx_r] <= {res_x, res_y};
    end
    work_q <= work_mem[j_r];
  end

  // State machine.
  assign pipe_empty = !rd_vld_r && !s1_vld_r && !s2_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (ev_acc) state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNTW'(1)) begin
          state_nxt = (n_r == '0) ? ST_DIRECT_RD : ST_LEVEL;
        end
      end
      ST_LEVEL:      if (j_r == lvl_r) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = (lvl_r == AW'(1)) ? ST_IDLE : ST_LEVEL;
        end
      end
      ST_DIRECT_RD:  state_nxt = ST_DIRECT_OUT;
      ST_DIRECT_OUT: state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Bit-serial division for t and level sequencing.
  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_d_r});

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (ev_acc) begin
          div_d_r <= steps_eff;
          dvd_r   <= {k_cl, {T_FRAC_BITS{1'b0}}} + DW'(steps_eff >> 1);
          rem_r   <= '0;
          cnt_r   <= DIV_N;
          last_r  <= (k_cl == steps_eff);
          n_r     <= n_eval;
        end
      end
      ST_DIV: begin
        rem_r <= q_bit ? STEPS_BITS'(rem_sh - {1'b0, div_d_r}) : STEPS_BITS'(rem_sh);
        dvd_r <= {dvd_r[DW-2:0], q_bit};
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          lvl_r   <= n_r;
          j_r     <= '0;
          first_r <= 1'b1;
        end
      end
      ST_LEVEL: begin
        j_r <= j_r + AW'(1);
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          lvl_r   <= lvl_r - AW'(1);
          j_r     <= '0;
          first_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Interpolation pipeline: read, difference, multiply, round and write back.
  assign t_s    = $signed({1'b0, dvd_r[TW-1:0]});
  assign cur_w  = rd_first_r ? ctrl_q : work_q;
  assign cur_x  = $signed(cur_w[WW-1:COORD_BITS]);
  assign cur_y  = $signed(cur_w[COORD_BITS-1:0]);
  assign prev_x = $signed(prev_r[WW-1:COORD_BITS]);
  assign prev_y = $signed(prev_r[COORD_BITS-1:0]);

  always_comb begin
    rnd_x = (prod_x_r + HALF) >>> T_FRAC_BITS;
    rnd_y = (prod_y_r + HALF) >>> T_FRAC_BITS;
    res_x = p2_x_r + COORD_BITS'(rnd_x);
    res_y = p2_y_r + COORD_BITS'(rnd_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_LEVEL);
      s1_vld_r <= rd_vld_r && (rd_idx_r != '0);
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= j_r;
    rd_first_r <= first_r;
    rd_final_r <= (lvl_r == AW'(1));
    if (rd_vld_r) begin
      prev_r     <= cur_w;
      diff_x_r   <= DFW'(cur_x) - DFW'(prev_x);
      diff_y_r   <= DFW'(cur_y) - DFW'(prev_y);
      p1_x_r     <= prev_x;
      p1_y_r     <= prev_y;
      w1_idx_r   <= rd_idx_r - AW'(1);
      s1_final_r <= rd_final_r;
    end
    prod_x_r   <= PW'(diff_x_r) * PW'(t_s);
    prod_y_r   <= PW'(diff_y_r) * PW'(t_s);
    p2_x_r     <= p1_x_r;
    p2_y_r     <= p1_y_r;
    w2_idx_r   <= w1_idx_r;
    s2_final_r <= s1_final_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (s2_vld_r && s2_final_r) || (state_r == ST_DIRECT_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIRECT_OUT) begin
      out_x_r    <= $signed(ctrl_q[WW-1:COORD_BITS]);
      out_y_r    <= $signed(ctrl_q[COORD_BITS-1:0]);
      out_last_r <= last_r;
    end else if (s2_vld_r && s2_final_r) begin
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_curve_x        = out_x_r;
  assign out_curve_y        = out_y_r;
  assign out_is_last_sample = out_last_r;

endmodule

// ----- rtl/core/bcpe_checker.sv -----
// ----------------------------------------------------------------------------
// bcpe_checker
// Port-level temporal checks for the Bezier curve point evaluator core.
// ----------------------------------------------------------------------------
`include "bezier_curve_point_evaluator_core_assert.svh"

module bcpe_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_opcode,
  input logic out_valid
);
  import bcpe_pkg::*;

  // A point write leaves the core idle.
  `BCPE_ASSERT_NEXT(a_write_no_busy, clk, rst_n,
                    start && !busy && in_opcode == OP_WRITE_POINT, !busy,
                    "point write made the core busy")

  // An evaluation holds the core busy and gives no result in the next cycle.
  `BCPE_ASSERT_NEXT(a_eval_busy, clk, rst_n,
                    start && !busy && in_opcode == OP_EVALUATE, busy && !out_valid,
                    "evaluation not started")

  // Every result comes from work that kept the core busy.
  `BCPE_ASSERT_SAME(a_result_after_busy, clk, rst_n, out_valid, $past(busy),
                    "result without a busy period")

  // A result strobe lasts one cycle.
  `BCPE_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid,
                    "result strobe held")

endmodule

bind bezier_curve_point_evaluator_core bcpe_checker u_bcpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_opcode (in_opcode),
  .out_valid (out_valid)
);
